// ===== rtl/core/mpo_pkg.sv =====
`default_nettype none

package mpo_pkg;

  // Waveform select codes
  localparam logic [1:0] WAVE_SINE     = 2'd0;
  localparam logic [1:0] WAVE_TRIANGLE = 2'd1;
  localparam logic [1:0] WAVE_SAW      = 2'd2;
  localparam logic [1:0] WAVE_SQUARE   = 2'd3;

  // Register indexes
  localparam int unsigned CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_WAVE_TYPE  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DUTY_LEVEL = 2'd2;

  localparam int unsigned PORT_PHASE_BITS = 32;
  localparam logic [PORT_PHASE_BITS-1:0] DUTY_RESET = 32'h8000_0000;

  localparam int unsigned DEF_LUT_ADDR_BITS = 9;
  localparam int unsigned DEF_SAMPLE_BITS   = 16;
  localparam int unsigned DEF_PHASE_BITS    = 32;

  // pi/2 in Q30
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  // Magnitude of sin(pi/2 * k/q), q = 2^(lut_bits-2), scaled to the sample range.
  // Evaluated at elaboration only.
  function automatic longint unsigned quarter_sine(input int unsigned k,
                                                   input int unsigned lut_bits,
                                                   input int unsigned sample_bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint unsigned half;
    longint unsigned mag;
    x    = (PI_HALF_Q30 * 64'(k)) >> (lut_bits - 2);
    x2   = (x * x) >> 30;
    half = 64'd1 << (sample_bits - 1);
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd272; sum = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd342; sum = sum - signed'(term);
    if (sum < 0) begin
      sum = 0;
    end
    mag = (unsigned'(sum) * half + (64'd1 << 29)) >> 30;
    if (mag > half - 64'd1) begin
      mag = half - 64'd1;
    end
    return mag;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/multiwave_phase_oscillator.sv =====
`default_nettype none

// Phase-accumulator oscillator giving one sine, triangle, saw or square sample
// per input beat. A beat may load a new phase first; the sample is taken at the
// current phase, then the signed step is added modulo one cycle and the new
// phase is returned with the sample. Throughput is one beat per clock while the
// output is not stalled; each beat passes an input register, then a result
// register. The rate is set by the combinational phase add, and the sine path
// (quarter-wave table read twice plus one 16-bit interpolation multiply) fits
// between the two registers. The sine table is constant, built at elaboration,
// so there is no start-up sweep. Configuration is taken at any time on its own
// channel and must only be written while no beat is in flight.

module multiwave_phase_oscillator #(
  parameter int unsigned LUT_ADDR_BITS = mpo_pkg::DEF_LUT_ADDR_BITS,
  parameter int unsigned SAMPLE_BITS   = mpo_pkg::DEF_SAMPLE_BITS,
  parameter int unsigned PHASE_BITS    = mpo_pkg::DEF_PHASE_BITS
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       cfg_valid,
  output logic                                            cfg_ready,
  input  wire logic [mpo_pkg::CFG_INDEX_BITS-1:0]         cfg_index,
  input  wire logic [31:0]                                cfg_data,
  input  wire logic                                       in_valid,
  output logic                                            in_ready,
  input  wire logic                                       load_phase,
  input  wire logic [mpo_pkg::PORT_PHASE_BITS-1:0]        phase_value,
  output logic                                            out_valid,
  input  wire logic                                       out_ready,
  output logic signed [SAMPLE_BITS-1:0]                   sample,
  output logic [mpo_pkg::PORT_PHASE_BITS-1:0]             phase_now
);

  localparam int unsigned QN        = 1 << (LUT_ADDR_BITS - 2);
  localparam int unsigned MAG_BITS  = SAMPLE_BITS - 1;
  localparam int unsigned FRAC_SPAN = PHASE_BITS - LUT_ADDR_BITS;
  localparam int unsigned FRAC_BITS = (FRAC_SPAN < 16) ? FRAC_SPAN : 16;
  localparam int unsigned FRAC_DROP = FRAC_SPAN - FRAC_BITS;
  localparam int unsigned PROD_W    = FRAC_BITS + SAMPLE_BITS + 2;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS+1:0] TRI_HALF =
    (SAMPLE_BITS+2)'(1) << (SAMPLE_BITS - 1);
  localparam logic signed [SAMPLE_BITS+1:0] TRI_MAX = (SAMPLE_BITS+2)'(S_MAX);
  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic [LUT_ADDR_BITS-2:0] QTOP = (LUT_ADDR_BITS-1)'(QN);

  typedef logic [QN:0][MAG_BITS-1:0] qtab_t;

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int i = 0; i <= int'(QN); i++) begin
      t[i] = MAG_BITS'(mpo_pkg::quarter_sine(i, LUT_ADDR_BITS, SAMPLE_BITS));
    end
    return t;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  // Configuration
  logic [1:0]              wave_type;
  logic signed [31:0]      phase_step;
  logic [PHASE_BITS-1:0]   duty_level;
  logic [PHASE_BITS-1:0]   step_ext;

  assign cfg_ready = 1'b1;
  assign step_ext  = PHASE_BITS'(phase_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_type  <= mpo_pkg::WAVE_SINE;
      phase_step <= '0;
      duty_level <= PHASE_BITS'(mpo_pkg::DUTY_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mpo_pkg::REG_WAVE_TYPE:  wave_type  <= cfg_data[1:0];
        mpo_pkg::REG_PHASE_STEP: phase_step <= signed'(cfg_data);
        mpo_pkg::REG_DUTY_LEVEL: duty_level <= PHASE_BITS'(cfg_data);
        default: ;
      endcase
    end
  end

  // Input stage and phase accumulator
  logic                  phase_load;
  logic                  s1_valid;
  logic                  s1_move;
  logic                  out_free;
  logic [PHASE_BITS-1:0] phase;
  logic [PHASE_BITS-1:0] phase_cur;
  logic [PHASE_BITS-1:0] phase_next;
  logic [PHASE_BITS-1:0] s1_phase;
  logic [PHASE_BITS-1:0] s1_next;

  assign out_free   = !out_valid || out_ready;
  assign s1_move    = s1_valid && out_free;
  assign in_ready   = !s1_valid || out_free;
  assign phase_load = in_valid && in_ready;
  assign phase_cur  = load_phase ? PHASE_BITS'(phase_value) : phase;
  assign phase_next = phase_cur + step_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (phase_load) begin
        phase <= phase_next;
      end
      if (phase_load) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (phase_load) begin
      s1_phase <= phase_cur;
      s1_next  <= phase_next;
    end
  end

  // Sine: quarter-wave table at two neighbouring points, then interpolate
  logic [LUT_ADDR_BITS-1:0]   idx_a;
  logic [LUT_ADDR_BITS-1:0]   idx_b;
  logic [LUT_ADDR_BITS-2:0]   taddr_a;
  logic [LUT_ADDR_BITS-2:0]   taddr_b;
  logic signed [SAMPLE_BITS-1:0] sin_a;
  logic signed [SAMPLE_BITS-1:0] sin_b;
  logic signed [SAMPLE_BITS:0]   sin_diff;
  logic [FRAC_BITS-1:0]          frac;
  logic signed [PROD_W-1:0]      prod;
  logic signed [PROD_W-1:0]      prod_rnd;
  logic signed [SAMPLE_BITS-1:0] sin_val;

  assign idx_a = s1_phase[PHASE_BITS-1 -: LUT_ADDR_BITS];
  assign idx_b = idx_a + LUT_ADDR_BITS'(1);
  assign frac  = s1_phase[FRAC_DROP +: FRAC_BITS];

  // Odd quadrants run the table backwards; the upper half is negated
  assign taddr_a = idx_a[LUT_ADDR_BITS-2] ?
                   QTOP - {1'b0, idx_a[LUT_ADDR_BITS-3:0]} : {1'b0, idx_a[LUT_ADDR_BITS-3:0]};
  assign taddr_b = idx_b[LUT_ADDR_BITS-2] ?
                   QTOP - {1'b0, idx_b[LUT_ADDR_BITS-3:0]} : {1'b0, idx_b[LUT_ADDR_BITS-3:0]};

  assign sin_a = idx_a[LUT_ADDR_BITS-1] ? -signed'({1'b0, QTAB[taddr_a]})
                                        :  signed'({1'b0, QTAB[taddr_a]});
  assign sin_b = idx_b[LUT_ADDR_BITS-1] ? -signed'({1'b0, QTAB[taddr_b]})
                                        :  signed'({1'b0, QTAB[taddr_b]});

  assign sin_diff = (SAMPLE_BITS+1)'(sin_b) - (SAMPLE_BITS+1)'(sin_a);
  assign prod     = PROD_W'(signed'({1'b0, frac})) * PROD_W'(sin_diff);
  assign prod_rnd = prod + RND_HALF;
  assign sin_val  = sin_a + SAMPLE_BITS'(prod_rnd >>> FRAC_BITS);

  // Saw and triangle from the top phase bits, square from the duty compare
  logic [SAMPLE_BITS-1:0]        saw_top;
  logic signed [SAMPLE_BITS-1:0] saw_val;
  logic signed [SAMPLE_BITS:0]   saw_abs;
  logic signed [SAMPLE_BITS+1:0] tri_wide;
  logic signed [SAMPLE_BITS-1:0] tri_val;
  logic signed [SAMPLE_BITS-1:0] sq_val;
  logic signed [SAMPLE_BITS-1:0] sample_next;

  if (PHASE_BITS >= SAMPLE_BITS) begin : g_top_down
    assign saw_top = s1_phase[PHASE_BITS-1 -: SAMPLE_BITS];
  end else begin : g_top_up
    assign saw_top = {s1_phase, {(SAMPLE_BITS-PHASE_BITS){1'b0}}};
  end

  assign saw_val  = signed'({~saw_top[SAMPLE_BITS-1], saw_top[SAMPLE_BITS-2:0]});
  assign saw_abs  = saw_val[SAMPLE_BITS-1] ? -(SAMPLE_BITS+1)'(saw_val)
                                           :  (SAMPLE_BITS+1)'(saw_val);
  assign tri_wide = ((SAMPLE_BITS+2)'(saw_abs) <<< 1) - TRI_HALF;
  assign tri_val  = (tri_wide > TRI_MAX) ? S_MAX : SAMPLE_BITS'(tri_wide);
  assign sq_val   = (s1_phase <= duty_level) ? S_MAX : S_MIN;

  always_comb begin
    case (wave_type)
      mpo_pkg::WAVE_SINE:     sample_next = sin_val;
      mpo_pkg::WAVE_TRIANGLE: sample_next = tri_val;
      mpo_pkg::WAVE_SAW:      sample_next = saw_val;
      default:                sample_next = sq_val;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      sample    <= sample_next;
      phase_now <= mpo_pkg::PORT_PHASE_BITS'(s1_next);
    end
  end

  // Checks
  a_hold_when_full: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input taken while both stages are full");

  a_out_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result shown with no item in the input stage");

  a_phase_advance: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !load_phase |=> phase == $past(phase + step_ext))
    else $error("phase did not advance by the step");

  a_stage_phase: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> s1_next == s1_phase + step_ext)
    else $error("stored next phase does not match stored phase plus step");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import mpo_pkg::*;

  localparam int LUT_BITS   = DEF_LUT_ADDR_BITS;
  localparam int SMP_BITS   = DEF_SAMPLE_BITS;
  localparam int PH_BITS    = DEF_PHASE_BITS;
  localparam int LUT_N      = 1 << LUT_BITS;
  localparam int FRAC_SPAN  = PH_BITS - LUT_BITS;
  localparam int FRAC_BITS  = (FRAC_SPAN < 16) ? FRAC_SPAN : 16;
  localparam int FRAC_DROP  = FRAC_SPAN - FRAC_BITS;
  localparam int TOP_SHIFT  = PH_BITS - SMP_BITS;
  localparam longint HALF   = longint'(1) << (SMP_BITS - 1);
  localparam int MAX_REPORT = 20;

  // index 3 is decoded by nobody; a write there must change nothing
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic        load;
    logic [31:0] value;
  } tone_item_t;

  typedef struct packed {
    logic signed [SMP_BITS-1:0] sample_v;
    logic [PH_BITS-1:0]         phase_v;
  } osc_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [31:0]               cfg_data  = '0;
  logic                      in_valid  = 1'b0;
  logic                      in_ready;
  logic                      load_phase  = 1'b0;
  logic [31:0]               phase_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [SMP_BITS-1:0] sample;
  logic [31:0]               phase_now;

  multiwave_phase_oscillator u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .load_phase (load_phase),
    .phase_value(phase_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample     (sample),
    .phase_now  (phase_now)
  );

  always #5 clk = ~clk;

  // mirror of the oscillator
  longint             sine_rom [0:LUT_N];
  logic [1:0]         cur_wave = WAVE_SINE;
  logic [31:0]        cur_step = '0;
  logic [31:0]        cur_duty = DUTY_RESET;
  logic [PH_BITS-1:0] osc_phase = '0;

  tone_item_t  pending_tones [$];
  osc_result_t expected_ticks [$];

  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  int in_gap       = 0;
  int out_gap      = 0;
  int err_count    = 0;
  int beats_in     = 0;
  int results_seen = 0;
  int regs_written = 0;

  function automatic longint quarter_mag(input int unsigned k, input int unsigned q);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned mag;
    longint          acc;
    x    = (PI_HALF_Q30 * longint'(k)) / q;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (int n = 1; n <= 9; n++) begin
      term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    mag = (longint'(acc) * HALF + (longint'(1) << 29)) >> 30;
    if (mag > HALF - 1) mag = HALF - 1;
    return longint'(mag);
  endfunction

  function automatic logic signed [SMP_BITS-1:0] wave_sample(input logic [PH_BITS-1:0] p);
    longint idx;
    longint frac;
    longint a;
    longint b;
    longint num;
    longint s;
    case (cur_wave)
      WAVE_SINE: begin
        idx  = longint'(p >> FRAC_SPAN) & (LUT_N - 1);
        frac = longint'(p >> FRAC_DROP) & ((longint'(1) << FRAC_BITS) - 1);
        a    = sine_rom[idx];
        b    = sine_rom[idx + 1];
        num  = a * (longint'(1) << FRAC_BITS) + frac * (b - a);
        num  = num + HALF * (longint'(1) << FRAC_BITS) + (longint'(1) << (FRAC_BITS - 1));
        s    = (num >>> FRAC_BITS) - HALF;
      end
      WAVE_TRIANGLE: begin
        s = longint'(p >> TOP_SHIFT) - HALF;
        if (s < 0) s = -s;
        s = 2 * s - HALF;
        if (s > HALF - 1) s = HALF - 1;
      end
      WAVE_SAW: s = longint'(p >> TOP_SHIFT) - HALF;
      default:  s = (p <= cur_duty) ? HALF - 1 : -HALF;
    endcase
    return s[SMP_BITS-1:0];
  endfunction

  task automatic predict_tick(input logic load, input logic [31:0] value);
    osc_result_t r;
    if (load) osc_phase = value;
    r.sample_v = wave_sample(osc_phase);
    osc_phase  = osc_phase + cur_step;
    r.phase_v  = osc_phase;
    expected_ticks.push_back(r);
  endtask

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_REPORT) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic queue_tone(input logic load, input logic [31:0] value);
    tone_item_t t;
    t.load  = load;
    t.value = value;
    pending_tones.push_back(t);
  endtask

  // the last pop may land on the same edge as the check; look again once settled
  task automatic drain_ticks();
    do begin
      while (pending_tones.size() != 0 || in_valid || expected_ticks.size() != 0)
        @(posedge clk);
      repeat (4) @(posedge clk);
    end while (pending_tones.size() != 0 || in_valid || expected_ticks.size() != 0);
  endtask

  // registers change only with nothing in flight
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] data);
    drain_ticks();
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_WAVE_TYPE:  cur_wave = data[1:0];
      REG_PHASE_STEP: cur_step = data;
      REG_DUTY_LEVEL: cur_duty = data;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    regs_written++;
  endtask

  task automatic apply_setting(input logic [1:0] wv, input logic [31:0] stp,
                               input logic [31:0] dty);
    write_reg(REG_WAVE_TYPE, {30'd0, wv});
    write_reg(REG_PHASE_STEP, stp);
    write_reg(REG_DUTY_LEVEL, dty);
  endtask

  always @(posedge clk) begin : drive_tones
    tone_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_tick(load_phase, phase_value);
        beats_in++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (in_idle_pct != 0 && $urandom_range(0, 99) < in_idle_pct) begin
          in_gap = $urandom_range(0, 2);
          in_valid <= 1'b0;
        end else if (pending_tones.size() != 0) begin
          nxt = pending_tones.pop_front();
          load_phase  <= nxt.load;
          phase_value <= nxt.value;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_ticks
    osc_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_ticks.size() == 0) begin
          report_mismatch($sformatf("unexpected beat sample %0d phase %h", sample, phase_now));
        end else begin
          want = expected_ticks.pop_front();
          if (sample !== want.sample_v)
            report_mismatch($sformatf("sample %0d, want %0d", sample, want.sample_v));
          if (phase_now !== want.phase_v)
            report_mismatch($sformatf("phase_now %h, want %h", phase_now, want.phase_v));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (out_idle_pct != 0 && $urandom_range(0, 99) < out_idle_pct) begin
        out_gap = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : run_stimulus
    logic [1:0]  wave_cycle [4];
    logic [1:0]  wv;
    logic [31:0] stp;
    logic [31:0] dty;
    logic [31:0] v;
    int          j;
    int          r;
    wave_cycle = '{WAVE_SINE, WAVE_TRIANGLE, WAVE_SAW, WAVE_SQUARE};
    // quarter-wave symmetry, sign from the quadrant
    for (int i = 0; i <= LUT_N; i++) begin
      j = i % LUT_N;
      r = j % (LUT_N / 4);
      if ((j / (LUT_N / 4)) % 2 == 1) sine_rom[i] = quarter_mag(LUT_N / 4 - r, LUT_N / 4);
      else sine_rom[i] = quarter_mag(r, LUT_N / 4);
      if ((j / (LUT_N / 4)) >= 2) sine_rom[i] = -sine_rom[i];
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings first, then the corners of each waveform
    in_idle_pct  = 20;
    out_idle_pct = 20;
    queue_tone(1'b0, 32'h0000_0000);
    queue_tone(1'b1, 32'hFFFF_FFFF);
    write_reg(REG_SPARE, 32'hDEAD_BEEF);
    queue_tone(1'b1, 32'h4000_0000);

    apply_setting(WAVE_SINE, 32'hFFFF_FFFF, DUTY_RESET);
    queue_tone(1'b1, 32'h0000_0000);
    queue_tone(1'b0, 32'h1234_5678);
    queue_tone(1'b1, 32'h2000_0080);

    apply_setting(WAVE_TRIANGLE, 32'h8000_0000, DUTY_RESET);
    queue_tone(1'b1, 32'h0000_0000);
    queue_tone(1'b0, 32'hFFFF_FFFF);
    queue_tone(1'b1, 32'h7FFF_FFFF);
    queue_tone(1'b1, 32'hC000_0000);

    apply_setting(WAVE_SAW, 32'h7FFF_FFFF, DUTY_RESET);
    queue_tone(1'b1, 32'h0000_0000);
    queue_tone(1'b1, 32'hFFFF_FFFF);
    queue_tone(1'b0, 32'h0000_0000);

    apply_setting(WAVE_SQUARE, 32'h0000_0000, 32'h0000_0000);
    queue_tone(1'b1, 32'h0000_0000);
    queue_tone(1'b1, 32'h0000_0001);
    write_reg(REG_DUTY_LEVEL, 32'hFFFF_FFFF);
    queue_tone(1'b1, 32'hFFFF_FFFF);
    queue_tone(1'b1, 32'h0000_0000);
    write_reg(REG_DUTY_LEVEL, DUTY_RESET);
    queue_tone(1'b1, 32'h8000_0000);
    queue_tone(1'b1, 32'h8000_0001);

    // random settings, each wave twice; the last stretch runs without idling
    for (int ph = 0; ph < 8; ph++) begin
      wv = wave_cycle[ph % 4];
      case ($urandom_range(0, 5))
        0:       stp = $urandom_range(1, 4096);
        1:       stp = 32'd0 - $urandom_range(1, 4096);
        2:       stp = 32'h8000_0000;
        3:       stp = 32'h7FFF_FFFF;
        default: stp = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0:       dty = 32'h0000_0000;
        1:       dty = 32'hFFFF_FFFF;
        default: dty = $urandom;
      endcase
      apply_setting(wv, stp, dty);
      if (ph == 7) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = 15 * $urandom_range(0, 2);
        out_idle_pct = 15 * $urandom_range(0, 2);
      end
      for (int n = 0; n < 50; n++) begin
        // hug the switch point of the square wave
        if (wv == WAVE_SQUARE && $urandom_range(0, 1) == 1) v = dty + $urandom_range(0, 2) - 1;
        else v = $urandom;
        queue_tone($urandom_range(0, 4) == 0, v);
      end
    end

    drain_ticks();
    repeat (8) @(posedge clk);
    $display("covered %0d input beats and %0d checked results over all four waveforms,",
             beats_in, results_seen);
    $display("with %0d register writes including step and duty extremes", regs_written);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== multiwave_phase_oscillator.f =====
rtl/core/mpo_pkg.sv
rtl/core/multiwave_phase_oscillator.sv
bench/testbench.sv
